@@ design/hss_pkg.sv @@
// Package for the harmonic sine synthesizer: shared types, constants and
// the quarter-wave sine table generator. No dependencies.
`timescale 1ns / 1ps

package hss_pkg;

  // Fixed field widths
  localparam int AMP_W    = 16;   // signed Q3.12 amplitude
  localparam int SUM_W    = 24;   // signed Q11.12 sum
  localparam int PEAK_W   = 23;   // unsigned peak magnitude
  localparam int SINE_W   = 15;   // unsigned quarter-wave entry, Q1.14
  localparam int PROD_W   = 32;   // amplitude times sine
  localparam int TERM_W   = 18;   // one rounded weighted term
  localparam int ACC_W    = 26;   // prior sum plus up to nine terms
  localparam int CFG_W    = 64;   // widest configuration register
  localparam int CIDX_W   = 3;    // configuration register index
  localparam int TERM_CW  = 4;    // term counter, 0 = fundamental
  localparam int HIDX_W   = 3;    // harmonic entry index
  localparam int IDX_PORT_W = 16; // sample index port

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_PHASE_STEP    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SAMPLE_OFFSET = 3'd1;
  localparam logic [CIDX_W-1:0] REG_FUND_AMP      = 3'd2;
  localparam logic [CIDX_W-1:0] REG_HARM_COUNT    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_HARM_NUMBERS  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_HARM_AMPS_LO  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_HARM_AMPS_HI  = 3'd6;

  localparam logic [AMP_W-1:0] FUND_AMP_RESET = 16'd4096;

  // Saturation limits on the accumulator
  localparam logic signed [ACC_W-1:0] ACC_MAX = 26'sd8388607;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -26'sd8388608;

  // Polynomial constants for the sine table, Q2.30
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_RUN,
    S_DRAIN,
    S_SAT,
    S_FINISH
  } hss_state_t;

  // Controller to datapath
  typedef struct packed {
    logic                load_in;
    logic                calc_base;
    logic                issue;
    logic [TERM_CW-1:0]  term;
    logic                do_sat;
    logic                do_finish;
  } hss_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic                pipe_empty;
    logic [TERM_CW-1:0]  num_harm;
    logic                out_free;
  } hss_status_t;

  // Quarter-wave entry k: Taylor series through x^9 in Q2.30, rounded to Q1.14.
  // Evaluated only at elaboration.
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
                                                   input int unsigned tbits);
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    a  = ((64'(k) * TWO_PI_Q30) + (64'd1 << (tbits - 1))) >> tbits;
    x2 = ((a * a) + (64'd1 << 29)) >> 30;
    t  = ONE_Q30 - x2 / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (((a * t) >> 30) + (64'd1 << 15)) >> 16;
    if (s > 64'd16384) begin
      s = 64'd16384;
    end
    return s[SINE_W-1:0];
  endfunction

endpackage

@@ design/hss_ctrl.sv @@
// Controller for the harmonic sine synthesizer: sequences input capture,
// term issue, pipeline drain and result hand-off. Depends on hss_pkg.
`timescale 1ns / 1ps

module hss_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hss_pkg::hss_status_t status,
  output hss_pkg::hss_cmd_t    cmd
);
  import hss_pkg::*;

  hss_state_t          state_r, state_nxt;
  logic [TERM_CW-1:0]  term_r, term_nxt;

  // State and term counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      term_r  <= '0;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        state_nxt = S_RUN;
        term_nxt  = '0;
      end
      S_RUN: begin
        if (term_r >= status.num_harm) begin
          state_nxt = S_DRAIN;
        end else begin
          term_nxt = term_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (status.pipe_empty) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_stall      = 1'b1;
    cmd.load_in   = 1'b0;
    cmd.calc_base = 1'b0;
    cmd.issue     = 1'b0;
    cmd.term      = term_r;
    cmd.do_sat    = 1'b0;
    cmd.do_finish = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_BASE:   cmd.calc_base = 1'b1;
      S_RUN:    cmd.issue     = 1'b1;
      S_DRAIN:  ;
      S_SAT:    cmd.do_sat    = 1'b1;
      S_FINISH: cmd.do_finish = status.out_free;
      default:  ;
    endcase
  end

  // Checks
  a_load_to_base: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> state_r == S_BASE)
    else $error("captured request did not move to base phase computation");

  a_issue_fills_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |=> !status.pipe_empty)
    else $error("issued term did not enter the datapath pipeline");

  a_sat_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_sat |-> status.pipe_empty)
    else $error("saturation started with terms still in flight");

endmodule

@@ design/hss_datapath.sv @@
// Datapath for the harmonic sine synthesizer: configuration registers, phase
// multipliers, sine ROM, weighting multiplier, accumulator, peak and output
// register. Depends on hss_pkg.
`timescale 1ns / 1ps

module hss_datapath #(
  parameter int HARMONICS       = 8,
  parameter int SINE_TABLE_BITS = 10,
  parameter int INDEX_BITS      = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hss_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [hss_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic [hss_pkg::IDX_PORT_W-1:0]    in_sample_index,
  input  logic signed [hss_pkg::SUM_W-1:0]  in_prior_sum,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hss_pkg::SUM_W-1:0]  out_sample_sum,
  output logic [hss_pkg::PEAK_W-1:0]        out_peak_magnitude,
  input  hss_pkg::hss_cmd_t                 cmd,
  output hss_pkg::hss_status_t              status
);
  import hss_pkg::*;

  localparam int IW      = (INDEX_BITS < IDX_PORT_W) ? INDEX_BITS : IDX_PORT_W;
  localparam int QUARTER = 2 ** (SINE_TABLE_BITS - 2);
  localparam int ROM_AW  = SINE_TABLE_BITS - 1;
  localparam int RW      = SINE_TABLE_BITS - 2;

  // Configuration registers
  logic [31:0]          phase_step_r;
  logic                 sample_offset_r;
  logic [AMP_W-1:0]     fund_amp_r;
  logic [TERM_CW-1:0]   harm_count_r;
  logic [CFG_W-1:0]     harm_numbers_r;
  logic [CFG_W-1:0]     harm_amps_lo_r;
  logic [CFG_W-1:0]     harm_amps_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= '0;
      sample_offset_r <= 1'b0;
      fund_amp_r      <= FUND_AMP_RESET;
      harm_count_r    <= '0;
      harm_numbers_r  <= '0;
      harm_amps_lo_r  <= '0;
      harm_amps_hi_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_STEP:    phase_step_r    <= cfg_wdata[31:0];
        REG_SAMPLE_OFFSET: sample_offset_r <= cfg_wdata[0];
        REG_FUND_AMP:      fund_amp_r      <= cfg_wdata[AMP_W-1:0];
        REG_HARM_COUNT:    harm_count_r    <= cfg_wdata[TERM_CW-1:0];
        REG_HARM_NUMBERS:  harm_numbers_r  <= cfg_wdata;
        REG_HARM_AMPS_LO:  harm_amps_lo_r  <= cfg_wdata;
        REG_HARM_AMPS_HI:  harm_amps_hi_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Count above the entry limit acts as the limit
  logic [TERM_CW-1:0] num_harm;
  assign num_harm = (harm_count_r > TERM_CW'(HARMONICS)) ? TERM_CW'(HARMONICS)
                                                         : harm_count_r;

  // Captured request
  logic [IW-1:0]            idx_r;
  logic signed [SUM_W-1:0]  prior_r;
  logic                     frame_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      idx_r   <= in_sample_index[IW-1:0];
      prior_r <= in_prior_sum;
      frame_r <= in_frame_start;
    end
  end

  // Base phase: (index + offset) * phase_step, modulo 2^32
  logic [IW:0]  pos;
  logic [31:0]  base_nxt;
  logic [31:0]  base_r;

  assign pos      = {1'b0, idx_r} + (IW+1)'(sample_offset_r);
  assign base_nxt = pos * phase_step_r;

  always_ff @(posedge clk) begin
    if (cmd.calc_base) begin
      base_r <= base_nxt;
    end
  end

  // Stage 1: term select and harmonic phase
  logic [HIDX_W-1:0]   hsel;
  logic [7:0]          mult;
  logic [AMP_W-1:0]    amp_sel;
  logic [2*CFG_W-1:0]  amps_all;
  logic [31:0]         phase_nxt;
  logic [31:0]         phase_r;
  logic [AMP_W-1:0]    amp1_r;
  logic                v1_r;

  assign hsel     = HIDX_W'(cmd.term - 1'b1);
  assign amps_all = {harm_amps_hi_r, harm_amps_lo_r};
  assign mult     = (cmd.term == '0) ? 8'd1 : harm_numbers_r[8*hsel +: 8];
  assign amp_sel  = (cmd.term == '0) ? fund_amp_r : amps_all[AMP_W*hsel +: AMP_W];
  assign phase_nxt = base_r * mult;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      phase_r <= phase_nxt;
      amp1_r  <= amp_sel;
    end
  end

  // Quarter-wave sine table, built at elaboration
  logic [SINE_W-1:0] sine_rom [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, SINE_TABLE_BITS);
  end

  // Stage 2: quadrant fold and table read
  logic [SINE_TABLE_BITS-1:0] ptop;
  logic [1:0]                 quad;
  logic [RW-1:0]              rem;
  logic [ROM_AW-1:0]          rom_addr;
  logic [SINE_W-1:0]          rom_q_r;
  logic                       neg_r;
  logic [AMP_W-1:0]           amp2_r;
  logic                       v2_r;

  assign ptop     = phase_r[31 -: SINE_TABLE_BITS];
  assign quad     = ptop[SINE_TABLE_BITS-1 -: 2];
  assign rem      = ptop[RW-1:0];
  assign rom_addr = quad[0] ? (ROM_AW'(QUARTER) - {1'b0, rem}) : {1'b0, rem};

  always_ff @(posedge clk) begin
    rom_q_r <= sine_rom[rom_addr];
    neg_r   <= quad[1];
    amp2_r  <= amp1_r;
  end

  // Stage 3: signed sine times amplitude
  logic signed [AMP_W-1:0]  sine_s;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic                     v3_r;

  assign sine_s   = neg_r ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});
  assign prod_nxt = $signed(amp2_r) * sine_s;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Accumulate rounded term: (prod + 2^13) >> 14, arithmetic
  logic signed [PROD_W-1:0] rnd;
  logic signed [TERM_W-1:0] term_w;
  logic signed [ACC_W-1:0]  acc_r;

  assign rnd    = prod_r + 32'sd8192;
  assign term_w = TERM_W'(rnd >>> 14);

  always_ff @(posedge clk) begin
    if (cmd.calc_base) begin
      acc_r <= ACC_W'(prior_r);
    end else if (v3_r) begin
      acc_r <= acc_r + ACC_W'(term_w);
    end
  end

  // Saturate to 24 bits
  logic signed [SUM_W-1:0] sat_nxt;
  logic signed [SUM_W-1:0] sat_r;

  always_comb begin
    if (acc_r > ACC_MAX) begin
      sat_nxt = SUM_W'(ACC_MAX);
    end else if (acc_r < ACC_MIN) begin
      sat_nxt = SUM_W'(ACC_MIN);
    end else begin
      sat_nxt = acc_r[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_sat) begin
      sat_r <= sat_nxt;
    end
  end

  // Magnitude and running peak; most negative sum clips to the max
  logic [PEAK_W-1:0]        mag;
  logic [PEAK_W-1:0]        peak_base;
  logic [PEAK_W-1:0]        peak_nxt;
  logic [PEAK_W-1:0]        peak_r;
  logic signed [SUM_W-1:0]  neg_sum;

  assign neg_sum = -sat_r;

  always_comb begin
    if (!sat_r[SUM_W-1]) begin
      mag = sat_r[PEAK_W-1:0];
    end else if (sat_r == SUM_W'(ACC_MIN)) begin
      mag = {PEAK_W{1'b1}};
    end else begin
      mag = neg_sum[PEAK_W-1:0];
    end
    peak_base = frame_r ? '0 : peak_r;
    peak_nxt  = (mag > peak_base) ? mag : peak_base;
  end

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0]  out_sum_r;
  logic [PEAK_W-1:0]        out_peak_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.do_finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      peak_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.do_finish) begin
        peak_r <= peak_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_finish) begin
      out_sum_r  <= sat_r;
      out_peak_r <= peak_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample_sum     = out_sum_r;
  assign out_peak_magnitude = out_peak_r;

  assign status.pipe_empty = !(v1_r || v2_r || v3_r);
  assign status.num_harm   = num_harm;
  assign status.out_free   = !out_valid_r || !out_stall;

endmodule

@@ design/harmonic_sine_synthesizer.sv @@
// Harmonic sine synthesizer top level: controller plus datapath.
// Depends on hss_pkg, hss_ctrl and hss_datapath.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries a sample index, a prior sum and
//   a frame-start flag. The result channel (out_valid / out_stall) returns the
//   saturated sum and the running peak magnitude. Registers are written over
//   the cfg_ port (cfg_we, cfg_index, cfg_wdata); the user must write them only
//   while no request is in flight, which the block does not enforce.
//   A request passes through a base phase step, an issue step for each term
//   through the shared phase multiplier, sine ROM and weighting multiplier, a
//   drain of the term pipeline into the accumulator, then a saturate and a
//   peak-update step. A new request is taken only after the previous one has
//   been handed to the output register.
//   The block takes a new request while the previous result still waits in the
//   output register; if that result is still stalled when the next one is
//   ready, the controller holds in its finish step until the slot frees.
//   Synchronous reset (rst_n low) clears the controller, pipeline valids, the
//   peak and the output valid, and loads register defaults (fundamental
//   amplitude 1.0, everything else zero).
module harmonic_sine_synthesizer #(
  parameter int HARMONICS       = 8,
  parameter int SINE_TABLE_BITS = 10,
  parameter int INDEX_BITS      = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hss_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [hss_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hss_pkg::IDX_PORT_W-1:0]    in_sample_index,
  input  logic signed [hss_pkg::SUM_W-1:0]  in_prior_sum,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hss_pkg::SUM_W-1:0]  out_sample_sum,
  output logic [hss_pkg::PEAK_W-1:0]        out_peak_magnitude
);
  import hss_pkg::*;

  hss_cmd_t    cmd;
  hss_status_t status;

  hss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  hss_datapath #(
    .HARMONICS       (HARMONICS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .INDEX_BITS      (INDEX_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_sample_index    (in_sample_index),
    .in_prior_sum       (in_prior_sum),
    .in_frame_start     (in_frame_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample_sum     (out_sample_sum),
    .out_peak_magnitude (out_peak_magnitude),
    .cmd                (cmd),
    .status             (status)
  );

endmodule
